// ===== sv/ordered_array_insert_remove_core_defines.svh =====
// Assertion macros shared by the ordered array core RTL.
// Depends on nothing; included by the modules that carry checks.
`ifndef ORDERED_ARRAY_INSERT_REMOVE_CORE_DEFINES_SVH
`define ORDERED_ARRAY_INSERT_REMOVE_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Plain property checked at every rising clock edge outside reset.
`define OAIR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("ordered array check failed");
// Same-cycle implication checked outside reset.
`define OAIR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ordered array check failed");
`else
`define OAIR_ASSERT(label, clk, rst_n, prop)
`define OAIR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/oair_pkg.sv =====
// Shared types and codes for the ordered array core.
// No dependencies; used by oair_ctrl, oair_cell and the top level.
package oair_pkg;

    // request opcodes as they arrive on the op port
    localparam logic [2:0] OP_GET    = 3'd0;
    localparam logic [2:0] OP_SET    = 3'd1;
    localparam logic [2:0] OP_PUSH   = 3'd2;
    localparam logic [2:0] OP_POP    = 3'd3;
    localparam logic [2:0] OP_INSERT = 3'd4;
    localparam logic [2:0] OP_REMOVE = 3'd5;

    localparam int OP_BITS    = 3;
    localparam int INDEX_BITS = 6;
    localparam int LENGTH_BITS = 7;
    localparam int COUNT_BITS = 32;

    // what every cell does this cycle, relative to pos and len
    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,  // hold
        ACT_SET    = 2'd1,  // pos <- value, [len, pos) <- undefined word
        ACT_INSERT = 2'd2,  // pos <- value, (pos, len] <- left neighbor
        ACT_REMOVE = 2'd3   // [pos, len-1) <- right neighbor, len-1 <- undefined
    } t_act;

    typedef struct packed {
        t_act act;
        logic rd_en;        // cell at pos drives its word onto the read bus
    } t_cell_cmd;

endpackage

// ===== sv/oair_ctrl.sv =====
// Request stage, opcode decode, fill level and change counter.
// Depends on oair_pkg and ordered_array_insert_remove_core_defines.svh.
`include "ordered_array_insert_remove_core_defines.svh"

module oair_ctrl #(
    parameter int CAPACITY = 64,
    parameter int CW       = 7
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [oair_pkg::OP_BITS-1:0]  i_op,
    input  logic [oair_pkg::INDEX_BITS-1:0] i_index,
    output oair_pkg::t_cell_cmd           o_cmd,
    output logic [CW-1:0]                 o_pos,
    output logic [CW-1:0]                 o_len,
    output logic                          o_valid,
    output logic                          o_ok,
    output logic [oair_pkg::COUNT_BITS-1:0] o_count
);

    localparam logic [CW-1:0] CAP = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE = CW'(1);

    logic                               r_exec;
    logic [oair_pkg::OP_BITS-1:0]       r_op;
    logic [oair_pkg::INDEX_BITS-1:0]    r_idx;
    logic [CW-1:0]                      r_len;
    logic [oair_pkg::COUNT_BITS-1:0]    r_count;
    logic                               r_valid;
    logic                               r_ok;

    logic [CW-1:0]        w_idx;
    logic                 w_ok;
    logic                 w_bump;
    logic [CW-1:0]        n_len;
    oair_pkg::t_cell_cmd  w_cmd;
    logic [CW-1:0]        w_pos;

    assign w_idx = CW'(r_idx);

    always_comb begin
        w_ok      = 1'b0;
        w_bump    = 1'b0;
        n_len     = r_len;
        w_pos     = w_idx;
        w_cmd.act = oair_pkg::ACT_NONE;
        w_cmd.rd_en = 1'b0;
        unique case (r_op)
            oair_pkg::OP_GET: begin
                w_ok        = w_idx < r_len;
                w_cmd.rd_en = w_ok;
            end
            oair_pkg::OP_SET: begin
                w_ok = w_idx < CAP;
                if (w_ok) begin
                    w_cmd.act = oair_pkg::ACT_SET;
                    if (w_idx >= r_len) begin
                        n_len  = w_idx + ONE;
                        w_bump = 1'b1;
                    end
                end
            end
            oair_pkg::OP_PUSH: begin
                w_ok  = r_len < CAP;
                w_pos = r_len;
                if (w_ok) begin
                    w_cmd.act = oair_pkg::ACT_SET;
                    n_len     = r_len + ONE;
                    w_bump    = 1'b1;
                end
            end
            oair_pkg::OP_POP: begin
                w_ok  = r_len != '0;
                w_pos = r_len - ONE;
                if (w_ok) begin
                    w_cmd.act   = oair_pkg::ACT_REMOVE;
                    w_cmd.rd_en = 1'b1;
                    n_len       = r_len - ONE;
                    w_bump      = 1'b1;
                end
            end
            oair_pkg::OP_INSERT: begin
                w_ok  = r_len < CAP;
                // clamp the position to the end of the array
                w_pos = (w_idx > r_len) ? r_len : w_idx;
                if (w_ok) begin
                    w_cmd.act = oair_pkg::ACT_INSERT;
                    n_len     = r_len + ONE;
                    w_bump    = 1'b1;
                end
            end
            oair_pkg::OP_REMOVE: begin
                w_ok = w_idx < r_len;
                if (w_ok) begin
                    w_cmd.act   = oair_pkg::ACT_REMOVE;
                    w_cmd.rd_en = 1'b1;
                    n_len       = r_len - ONE;
                    w_bump      = 1'b1;
                end
            end
            default: begin
                w_ok = 1'b0;
            end
        endcase
        if (!r_exec) begin
            w_cmd.act   = oair_pkg::ACT_NONE;
            w_cmd.rd_en = 1'b0;
        end
    end

    // request stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exec <= 1'b0;
        end else begin
            r_exec <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_op  <= i_op;
            r_idx <= i_index;
        end
    end

    // execute stage: state and result flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
            r_ok    <= 1'b0;
        end else begin
            r_valid <= r_exec;
            if (r_exec) begin
                r_ok <= w_ok;
                if (w_ok) begin
                    r_len <= n_len;
                end
                if (w_ok && w_bump) begin
                    r_count <= r_count + 32'd1;
                end
            end
        end
    end

    assign o_cmd   = w_cmd;
    assign o_pos   = w_pos;
    assign o_len   = r_len;
    assign o_valid = r_valid;
    assign o_ok    = r_ok;
    assign o_count = r_count;

    `OAIR_ASSERT(a_len_bound, i_clk, i_rst_n, r_len <= CAP)
    `OAIR_ASSERT_IMP(a_count_only_on_result, i_clk, i_rst_n,
        $past(i_rst_n) && (r_count != $past(r_count)), r_valid && r_ok)
    `OAIR_ASSERT_IMP(a_len_change_bumps, i_clk, i_rst_n,
        $past(i_rst_n) && (r_len != $past(r_len)), r_count == $past(r_count) + 32'd1)
    `OAIR_ASSERT_IMP(a_fail_keeps_len, i_clk, i_rst_n,
        $past(i_rst_n) && r_valid && !r_ok, r_len == $past(r_len))

endmodule

// ===== sv/oair_cell.sv =====
// One slot of the ordered array: holds a word, loads from its neighbors.
// Depends on oair_pkg.
module oair_cell #(
    parameter int VALUE_BITS = 64,
    parameter int CW         = 7,
    parameter int IDX        = 0
) (
    input  logic                  i_clk,
    input  oair_pkg::t_cell_cmd   i_cmd,
    input  logic [CW-1:0]         i_pos,
    input  logic [CW-1:0]         i_len,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic [VALUE_BITS-1:0] i_undef,
    input  logic [VALUE_BITS-1:0] i_left,
    input  logic [VALUE_BITS-1:0] i_right,
    output logic [VALUE_BITS-1:0] o_word,
    output logic [VALUE_BITS-1:0] o_read
);

    localparam logic [CW-1:0] MY_POS  = CW'(IDX);
    localparam logic [CW-1:0] MY_NEXT = CW'(IDX + 1);

    logic [VALUE_BITS-1:0] r_word;
    logic [VALUE_BITS-1:0] n_word;
    logic                  w_load;

    always_comb begin
        w_load = 1'b0;
        n_word = i_value;
        case (i_cmd.act)
            oair_pkg::ACT_SET: begin
                if (MY_POS == i_pos) begin
                    w_load = 1'b1;
                end else if (MY_POS >= i_len && MY_POS < i_pos) begin
                    w_load = 1'b1;
                    n_word = i_undef;
                end
            end
            oair_pkg::ACT_INSERT: begin
                if (MY_POS == i_pos) begin
                    w_load = 1'b1;
                end else if (MY_POS > i_pos && MY_POS <= i_len) begin
                    w_load = 1'b1;
                    n_word = i_left;
                end
            end
            oair_pkg::ACT_REMOVE: begin
                if (MY_NEXT == i_len) begin
                    w_load = 1'b1;
                    n_word = i_undef;
                end else if (MY_POS >= i_pos && MY_NEXT < i_len) begin
                    w_load = 1'b1;
                    n_word = i_right;
                end
            end
            default: begin
                w_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;
    assign o_read = (i_cmd.rd_en && MY_POS == i_pos) ? r_word : '0;

endmodule

// ===== sv/ordered_array_insert_remove_core.sv =====
// Top level of the ordered array core: request stage, cell chain, result.
// Depends on oair_pkg, oair_ctrl, oair_cell and the defines header.
`include "ordered_array_insert_remove_core_defines.svh"

// Usage
//   Request channel: drive op, index and value with start high; the request
//   is taken at a rising edge where start is high and busy is low. busy is
//   only high during reset, so one request can be taken every cycle.
//   Result channel: o_valid pulses for one cycle with ok, read_value,
//   length (fill level after the request, low 7 bits) and change_count.
//   The receiver cannot stall; each result shows for exactly one cycle.
//   A taken request is first held in the request stage registers, then
//   executed; the result is shown from the execute stage registers.
//   Throughput is one request per cycle: every cell of the chain picks its
//   left neighbor, its right neighbor, the new word or the undefined word
//   in parallel, so an insert or remove shift is done in the execute stage.
//   Configuration: i_cfg_we writes the undefined word, used to fill gaps of
//   a set past the end and the slot freed by pop and remove. Write it only
//   while no request is in flight.
//   Reset (synchronous, active low) clears the fill level, the change
//   counter and the undefined word; entries are not cleared, and only
//   written slots below the fill level are ever read.
module ordered_array_insert_remove_core #(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [oair_pkg::OP_BITS-1:0]        i_op,
    input  logic [oair_pkg::INDEX_BITS-1:0]     i_index,
    input  logic [VALUE_BITS-1:0]               i_value,
    input  logic                                i_cfg_we,
    input  logic [VALUE_BITS-1:0]               i_cfg_wdata,
    output logic                                o_valid,
    output logic                                o_ok,
    output logic [VALUE_BITS-1:0]               o_read_value,
    output logic [oair_pkg::LENGTH_BITS-1:0]    o_length,
    output logic [oair_pkg::COUNT_BITS-1:0]     o_change_count
);

    // position/length width: must hold CAPACITY and the 7-bit result field
    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam int CW    = (LEN_W > oair_pkg::LENGTH_BITS) ? LEN_W : oair_pkg::LENGTH_BITS;

    logic                  w_accept;
    logic [VALUE_BITS-1:0] r_value;       // request stage payload
    logic [VALUE_BITS-1:0] r_undef;       // configuration register
    logic [VALUE_BITS-1:0] r_read_value;  // result payload

    oair_pkg::t_cell_cmd   w_cmd;
    logic [CW-1:0]         w_pos;
    logic [CW-1:0]         w_len;
    logic                  w_valid;
    logic                  w_ok;
    logic [oair_pkg::COUNT_BITS-1:0] w_count;

    logic [VALUE_BITS-1:0] w_word [CAPACITY];
    logic [VALUE_BITS-1:0] w_rd   [CAPACITY];
    logic [VALUE_BITS-1:0] w_read;

    assign busy     = !i_rst_n;
    assign w_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_undef <= '0;
        end else if (i_cfg_we) begin
            r_undef <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_value <= i_value;
        end
    end

    oair_ctrl #(
        .CAPACITY (CAPACITY),
        .CW       (CW)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_op     (i_op),
        .i_index  (i_index),
        .o_cmd    (w_cmd),
        .o_pos    (w_pos),
        .o_len    (w_len),
        .o_valid  (w_valid),
        .o_ok     (w_ok),
        .o_count  (w_count)
    );

    // chain of cells; the ends see the undefined word as their outer neighbor
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VALUE_BITS-1:0] w_left;
        logic [VALUE_BITS-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = r_undef;
        end else begin : g_inner_l
            assign w_left = w_word[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = r_undef;
        end else begin : g_inner_r
            assign w_right = w_word[g+1];
        end

        oair_cell #(
            .VALUE_BITS (VALUE_BITS),
            .CW         (CW),
            .IDX        (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_pos   (w_pos),
            .i_len   (w_len),
            .i_value (r_value),
            .i_undef (r_undef),
            .i_left  (w_left),
            .i_right (w_right),
            .o_word  (w_word[g]),
            .o_read  (w_rd[g])
        );
    end

    // at most one cell drives a nonzero word, so an OR merges the read bus
    always_comb begin
        w_read = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_read = w_read | w_rd[k];
        end
    end

    always_ff @(posedge i_clk) begin
        r_read_value <= w_read;
    end

    assign o_valid        = w_valid;
    assign o_ok           = w_ok;
    assign o_read_value   = r_read_value;
    assign o_length       = w_len[oair_pkg::LENGTH_BITS-1:0];
    assign o_change_count = w_count;

    `OAIR_ASSERT_IMP(a_fail_reads_zero, i_clk, i_rst_n,
        o_valid && !o_ok, o_read_value == '0)
    `OAIR_ASSERT_IMP(a_idle_no_result, i_clk, i_rst_n,
        $past(i_rst_n, 2) && !$past(w_accept, 2), !o_valid)
    `OAIR_ASSERT_IMP(a_result_follows_request, i_clk, i_rst_n,
        $past(i_rst_n) && $past(i_rst_n, 2) && $past(w_accept, 2), o_valid)

endmodule

// ===== dv/ordered_array_result_checker.sv =====
// Result checker for the ordered array core: mirrors the array, predicts each result.
// Depends on oair_pkg; instantiated beside the core by ordered_array_insert_remove_core_test.
`timescale 1ns / 1ps

module ordered_array_result_checker #(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    input  logic                             busy,
    input  logic [oair_pkg::OP_BITS-1:0]     i_op,
    input  logic [oair_pkg::INDEX_BITS-1:0]  i_index,
    input  logic [VALUE_BITS-1:0]            i_value,
    input  logic                             i_cfg_we,
    input  logic [VALUE_BITS-1:0]            i_cfg_wdata,
    input  logic                             o_valid,
    input  logic                             o_ok,
    input  logic [VALUE_BITS-1:0]            o_read_value,
    input  logic [oair_pkg::LENGTH_BITS-1:0] o_length,
    input  logic [oair_pkg::COUNT_BITS-1:0]  o_change_count,
    output int                               mismatch_count,
    output int                               outstanding
);

    typedef struct {
        logic                             ok;
        logic [VALUE_BITS-1:0]            read_value;
        logic [oair_pkg::LENGTH_BITS-1:0] length;
        logic [oair_pkg::COUNT_BITS-1:0]  change_count;
    } t_array_result;

    // shadow copy of the array state
    logic [VALUE_BITS-1:0]           shadow_slots [CAPACITY];
    logic [VALUE_BITS-1:0]           shadow_undef;
    int                              shadow_fill;
    logic [oair_pkg::COUNT_BITS-1:0] shadow_version;

    t_array_result predicted_results [$];
    int            errors_seen;

    initial begin
        errors_seen = 0;
    end

    task automatic apply_array_op(input logic [oair_pkg::OP_BITS-1:0] op,
                                  input logic [oair_pkg::INDEX_BITS-1:0] idx,
                                  input logic [VALUE_BITS-1:0] val);
        t_array_result res;
        int            pos;
        int            slot;
        res.ok         = 1'b0;
        res.read_value = '0;
        pos            = int'(idx);
        case (op)
            oair_pkg::OP_GET: begin
                if (pos < shadow_fill) begin
                    res.read_value = shadow_slots[pos];
                    res.ok         = 1'b1;
                end
            end
            oair_pkg::OP_SET: begin
                if (pos < shadow_fill) begin
                    shadow_slots[pos] = val;
                    res.ok            = 1'b1;
                end else if (pos < CAPACITY) begin
                    // gap between old end and target takes the undefined word
                    for (slot = shadow_fill; slot < pos; slot++)
                        shadow_slots[slot] = shadow_undef;
                    shadow_slots[pos] = val;
                    shadow_fill       = pos + 1;
                    shadow_version++;
                    res.ok            = 1'b1;
                end
            end
            oair_pkg::OP_PUSH: begin
                if (shadow_fill < CAPACITY) begin
                    shadow_slots[shadow_fill] = val;
                    shadow_fill++;
                    shadow_version++;
                    res.ok = 1'b1;
                end
            end
            oair_pkg::OP_POP: begin
                if (shadow_fill > 0) begin
                    res.read_value               = shadow_slots[shadow_fill-1];
                    shadow_slots[shadow_fill-1]  = shadow_undef;
                    shadow_fill--;
                    shadow_version++;
                    res.ok = 1'b1;
                end
            end
            oair_pkg::OP_INSERT: begin
                if (shadow_fill < CAPACITY) begin
                    if (pos > shadow_fill)
                        pos = shadow_fill;
                    for (slot = shadow_fill; slot > pos; slot--)
                        shadow_slots[slot] = shadow_slots[slot-1];
                    shadow_slots[pos] = val;
                    shadow_fill++;
                    shadow_version++;
                    res.ok = 1'b1;
                end
            end
            oair_pkg::OP_REMOVE: begin
                if (pos < shadow_fill) begin
                    res.read_value = shadow_slots[pos];
                    for (slot = pos + 1; slot < shadow_fill; slot++)
                        shadow_slots[slot-1] = shadow_slots[slot];
                    shadow_slots[shadow_fill-1] = shadow_undef;
                    shadow_fill--;
                    shadow_version++;
                    res.ok = 1'b1;
                end
            end
            default: ;  // reserved opcodes fail and change nothing
        endcase
        res.length       = oair_pkg::LENGTH_BITS'(shadow_fill);
        res.change_count = shadow_version;
        predicted_results.push_back(res);
    endtask

    always @(posedge i_clk) begin
        t_array_result want;
        if (!i_rst_n) begin
            predicted_results.delete();
            shadow_fill    = 0;
            shadow_version = '0;
            shadow_undef   = '0;
            foreach (shadow_slots[k])
                shadow_slots[k] = '0;
        end else begin
            if (o_valid) begin
                if (predicted_results.size() == 0) begin
                    $error("result with no request pending");
                    errors_seen++;
                end else begin
                    want = predicted_results.pop_front();
                    if (o_ok !== want.ok) begin
                        $error("ok: expected %0d, actual %0d", want.ok, o_ok);
                        errors_seen++;
                    end
                    if (o_read_value !== want.read_value) begin
                        $error("read_value: expected %h, actual %h",
                               want.read_value, o_read_value);
                        errors_seen++;
                    end
                    if (o_length !== want.length) begin
                        $error("length: expected %0d, actual %0d", want.length, o_length);
                        errors_seen++;
                    end
                    if (o_change_count !== want.change_count) begin
                        $error("change_count: expected %0d, actual %0d",
                               want.change_count, o_change_count);
                        errors_seen++;
                    end
                end
            end
            if (i_cfg_we)
                shadow_undef = i_cfg_wdata;
            if (start && !busy)
                apply_array_op(i_op, i_index, i_value);
        end
        mismatch_count <= errors_seen;
        outstanding    <= predicted_results.size();
    end

endmodule

// ===== dv/ordered_array_insert_remove_core_test.sv =====
// Top of the ordered array core testbench: clock, reset, request stimulus, verdict.
// Depends on oair_pkg, the core RTL and ordered_array_result_checker.
`timescale 1ns / 1ps

module ordered_array_insert_remove_core_test;

    localparam int CAPACITY       = 64;
    localparam int VALUE_BITS     = 64;
    localparam int PHASES         = 8;
    localparam int PHASE_REQUESTS = 141;
    // drain margin past the request and execute stages of the last request
    localparam int DRAIN_CYCLES   = 6;
    // longest correct quiet stretch is a burst gap or a drain, well below this
    localparam int WATCHDOG_LIMIT = 400;

    // reserved opcodes; the core must fail them and leave the array alone
    localparam logic [oair_pkg::OP_BITS-1:0] OP_RESERVED_6 = 3'd6;
    localparam logic [oair_pkg::OP_BITS-1:0] OP_RESERVED_7 = 3'd7;

    logic                             i_clk        = 1'b0;
    logic                             i_rst_n      = 1'b0;
    logic                             start        = 1'b0;
    logic                             busy;
    logic [oair_pkg::OP_BITS-1:0]     i_op         = oair_pkg::OP_GET;
    logic [oair_pkg::INDEX_BITS-1:0]  i_index      = '0;
    logic [VALUE_BITS-1:0]            i_value      = '0;
    logic                             i_cfg_we     = 1'b0;
    logic [VALUE_BITS-1:0]            i_cfg_wdata  = '0;
    logic                             o_valid;
    logic                             o_ok;
    logic [VALUE_BITS-1:0]            o_read_value;
    logic [oair_pkg::LENGTH_BITS-1:0] o_length;
    logic [oair_pkg::COUNT_BITS-1:0]  o_change_count;

    int mismatch_count;
    int outstanding;
    int quiet_cycles = 0;

    ordered_array_insert_remove_core #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_index        (i_index),
        .i_value        (i_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_valid        (o_valid),
        .o_ok           (o_ok),
        .o_read_value   (o_read_value),
        .o_length       (o_length),
        .o_change_count (o_change_count)
    );

    ordered_array_result_checker #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_index        (i_index),
        .i_value        (i_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_valid        (o_valid),
        .o_ok           (o_ok),
        .o_read_value   (o_read_value),
        .o_length       (o_length),
        .o_change_count (o_change_count),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // watchdog: any accepted request or result resets the quiet count
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("ordered_array_insert_remove_core_test: errors");
            $finish;
        end
    end

    // Drive one request and return at the edge that takes it. start stays
    // high, so the next call can follow at that same edge with no bubble.
    task automatic send_request(input logic [oair_pkg::OP_BITS-1:0] op,
                                input logic [oair_pkg::INDEX_BITS-1:0] idx,
                                input logic [VALUE_BITS-1:0] val);
        start   <= 1'b1;
        i_op    <= op;
        i_index <= idx;
        i_value <= val;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
    endtask

    // Undefined word is only written with the pipeline empty. Every request
    // makes a result, so no results pending plus the drain means idle.
    task automatic load_undefined_word(input logic [VALUE_BITS-1:0] word);
        start <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= word;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Random request. Grow phases lean on set/push/insert to reach a full
    // array; shrink phases lean on pop/remove to drain it back to empty.
    task automatic pick_request(input bit grow,
                                output logic [oair_pkg::OP_BITS-1:0] op,
                                output logic [oair_pkg::INDEX_BITS-1:0] idx,
                                output logic [VALUE_BITS-1:0] val);
        int roll;
        roll = $urandom_range(0, 99);
        if (grow) begin
            if (roll < 15)      op = oair_pkg::OP_GET;
            else if (roll < 33) op = oair_pkg::OP_SET;
            else if (roll < 53) op = oair_pkg::OP_PUSH;
            else if (roll < 75) op = oair_pkg::OP_INSERT;
            else if (roll < 86) op = oair_pkg::OP_POP;
            else if (roll < 97) op = oair_pkg::OP_REMOVE;
            else                op = (roll[0]) ? OP_RESERVED_7 : OP_RESERVED_6;
        end else begin
            if (roll < 15)      op = oair_pkg::OP_GET;
            else if (roll < 20) op = oair_pkg::OP_SET;
            else if (roll < 25) op = oair_pkg::OP_PUSH;
            else if (roll < 30) op = oair_pkg::OP_INSERT;
            else if (roll < 63) op = oair_pkg::OP_POP;
            else if (roll < 97) op = oair_pkg::OP_REMOVE;
            else                op = (roll[0]) ? OP_RESERVED_7 : OP_RESERVED_6;
        end
        // small indexes land inside the array more often; full range too
        if ($urandom_range(0, 9) < 6)
            idx = oair_pkg::INDEX_BITS'($urandom_range(0, 15));
        else
            idx = oair_pkg::INDEX_BITS'($urandom_range(0, 63));
        // shrink phases keep set near the front so it does not refill
        if (!grow && op == oair_pkg::OP_SET)
            idx = oair_pkg::INDEX_BITS'($urandom_range(0, 7));
        roll = $urandom_range(0, 19);
        if (roll == 0)      val = '0;
        else if (roll == 1) val = '1;
        else                val = VALUE_BITS'({$urandom, $urandom});
    endtask

    task automatic run_phase(input int count, input bit grow, input bit steady);
        logic [oair_pkg::OP_BITS-1:0]    op;
        logic [oair_pkg::INDEX_BITS-1:0] idx;
        logic [VALUE_BITS-1:0]           val;
        int                              sent;
        int                              burst;
        int                              gap;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && sent < count) begin
                pick_request(grow, op, idx, val);
                send_request(op, idx, val);
                burst--;
                sent++;
            end
            gap = steady ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        logic [VALUE_BITS-1:0] cfg_word;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        load_undefined_word('1);

        // Directed: empty-array failures, reserved ops, set past the end
        // with gap fill, clamped insert, full-array failures, removes.
        send_request(oair_pkg::OP_GET,    6'd0,  '0);
        send_request(oair_pkg::OP_POP,    6'd0,  '0);
        send_request(oair_pkg::OP_REMOVE, 6'd0,  '0);
        send_request(OP_RESERVED_6,       6'd0,  '1);
        send_request(OP_RESERVED_7,       6'd63, '1);
        send_request(oair_pkg::OP_SET,    6'd5,  '1);
        send_request(oair_pkg::OP_GET,    6'd2,  '0);
        send_request(oair_pkg::OP_SET,    6'd2,  '0);
        send_request(oair_pkg::OP_INSERT, 6'd63, VALUE_BITS'({$urandom, $urandom}));
        send_request(oair_pkg::OP_INSERT, 6'd0,  VALUE_BITS'({$urandom, $urandom}));
        send_request(oair_pkg::OP_GET,    6'd7,  '0);
        send_request(oair_pkg::OP_REMOVE, 6'd63, '0);
        send_request(oair_pkg::OP_REMOVE, 6'd0,  '0);
        send_request(oair_pkg::OP_POP,    6'd0,  '0);
        send_request(oair_pkg::OP_SET,    6'd63, VALUE_BITS'({$urandom, $urandom}));
        send_request(oair_pkg::OP_PUSH,   6'd0,  '1);
        send_request(oair_pkg::OP_INSERT, 6'd10, '1);
        send_request(oair_pkg::OP_SET,    6'd63, '0);
        send_request(oair_pkg::OP_GET,    6'd63, '0);
        send_request(oair_pkg::OP_GET,    6'd40, '0);
        send_request(oair_pkg::OP_REMOVE, 6'd63, '0);
        send_request(oair_pkg::OP_PUSH,   6'd0,  VALUE_BITS'({$urandom, $urandom}));
        send_request(oair_pkg::OP_POP,    6'd0,  '0);
        send_request(oair_pkg::OP_GET,    6'd62, '0);

        // Random phases alternate growth and drain, each under a new
        // undefined word; one phase runs with no sender gaps at all.
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       cfg_word = '0;
                3:       cfg_word = '1;
                5:       cfg_word = {VALUE_BITS/2{2'b10}};
                default: cfg_word = VALUE_BITS'({$urandom, $urandom});
            endcase
            load_undefined_word(cfg_word);
            run_phase(PHASE_REQUESTS, (phase % 2) == 0, phase == 2);
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && outstanding == 0) begin
            $display("ordered_array_insert_remove_core_test: clean");
        end else begin
            $display("ordered_array_insert_remove_core_test: errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/oair_pkg.sv
sv/oair_ctrl.sv
sv/oair_cell.sv
sv/ordered_array_insert_remove_core.sv
dv/ordered_array_result_checker.sv
dv/ordered_array_insert_remove_core_test.sv
